// ===== sv/wsqs_pkg.sv =====
// wsqs_pkg: types and constants shared by the work-stealing queue selector
// request and result payloads, controller state, command and status structs
// no dependencies
`timescale 1ns / 1ps

package wsqs_pkg;

    localparam int WID_W = 4;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [WID_W-1:0] worker_id;
        logic             from_worker;
    } t_req;

    typedef struct packed {
        logic [WID_W-1:0] target_worker;
        logic             granted;
        logic             stolen;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic req_load;
        logic tgt_load;
        logic scan_init;
        logic scan_step;
        logic cnt_wr;
        logic steal_found;
        logic steal_miss;
        logic res_emit;
        logic res_grant;
        logic res_steal;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic refused;
        logic cnt_ok;
        logic scan_last;
    } t_sts;

endpackage

// ===== sv/wsqs_ctrl.sv =====
// wsqs_ctrl: sequencing state machine of the queue selector
// drives datapath commands from its status; depends on wsqs_pkg
`timescale 1ns / 1ps

module wsqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  wsqs_pkg::t_sts i_sts,
    output wsqs_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import wsqs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.tgt_load = 1'b1;
                if (i_sts.refused) begin
                    o_cmd.res_emit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.cnt_ok) begin
                    o_cmd.cnt_wr    = 1'b1;
                    o_cmd.res_emit  = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.is_push) begin
                    o_cmd.res_emit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.cnt_ok) begin
                    o_cmd.cnt_wr      = 1'b1;
                    o_cmd.steal_found = 1'b1;
                    o_cmd.res_emit    = 1'b1;
                    o_cmd.res_grant   = 1'b1;
                    o_cmd.res_steal   = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_sts.scan_last) begin
                    o_cmd.steal_miss = 1'b1;
                    o_cmd.res_emit   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/wsqs_dp.sv =====
// wsqs_dp: job count memory, push and steal pointers, scan position, result register
// follows commands from wsqs_ctrl; depends on wsqs_pkg
`timescale 1ns / 1ps

module wsqs_dp #(
    parameter int MAX_WORKERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wsqs_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [wsqs_pkg::CFG_W-1:0]  i_cfg_data,
    input  wsqs_pkg::t_cmd              i_cmd,
    output wsqs_pkg::t_sts              o_sts,
    output wsqs_pkg::t_res              o_res,
    output logic                        o_done
);
    import wsqs_pkg::*;

    localparam int PW = $clog2(MAX_WORKERS);
    localparam int NW = $clog2(MAX_WORKERS + 1);
    localparam int RST_N = (MAX_WORKERS < int'(ACTIVE_RESET)) ? MAX_WORKERS
                                                              : int'(ACTIVE_RESET);

    logic [NW-1:0]          r_n;
    t_req                   r_req;
    logic [PW-1:0]          r_tgt;
    logic [PW-1:0]          n_tgt;
    logic [PW-1:0]          r_push_ptr;
    logic [PW-1:0]          r_steal_ptr;
    logic [PW-1:0]          r_start;
    logic [PW-1:0]          r_idx;
    logic [COUNT_WIDTH-1:0] r_mem [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;
    t_res                   r_res;
    logic                   r_done;

    logic                   w_is_push;
    logic                   w_outside;
    logic                   w_wid_ok;
    logic [PW-1:0]          w_push_q;
    logic [PW-1:0]          w_steal_start;
    logic [PW-1:0]          w_dec_tgt;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [COUNT_WIDTH-1:0] w_cnt_new;
    logic [NW-1:0]          w_cfg_n;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p, input logic [NW-1:0] n);
        logic [31:0] s;
        s = 32'(p) + 32'd1;
        return (s >= 32'(n)) ? '0 : PW'(s);
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_n = NW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WORKERS)) begin
            w_cfg_n = NW'(MAX_WORKERS);
        end else begin
            w_cfg_n = NW'(i_cfg_data);
        end
    end

    assign w_is_push     = (r_req.action == ACT_PUSH);
    assign w_outside     = w_is_push && !r_req.from_worker;
    assign w_wid_ok      = 32'(r_req.worker_id) < 32'(r_n);
    assign w_push_q      = (32'(r_push_ptr) < 32'(r_n)) ? r_push_ptr : '0;
    assign w_steal_start = (32'(r_steal_ptr) < 32'(r_n)) ? r_steal_ptr : '0;
    assign w_dec_tgt     = w_outside ? w_push_q : PW'(r_req.worker_id);
    assign w_cnt         = r_rd_vld ? r_rd_data : '0;
    assign w_cnt_new     = w_is_push ? (w_cnt + COUNT_WIDTH'(1)) : (w_cnt - COUNT_WIDTH'(1));

    assign o_sts.is_push   = w_is_push;
    assign o_sts.refused   = !w_outside && !w_wid_ok;
    assign o_sts.cnt_ok    = w_is_push ? (w_cnt != '1) : (w_cnt != '0);
    assign o_sts.scan_last = (32'(r_idx) + 32'd1) == 32'(r_n);

    always_comb begin
        n_tgt = r_tgt;
        if (i_cmd.tgt_load) begin
            n_tgt = w_dec_tgt;
        end else if (i_cmd.scan_init) begin
            n_tgt = w_steal_start;
        end else if (i_cmd.scan_step) begin
            n_tgt = f_next(r_tgt, r_n);
        end
    end

    // count memory, read at the next target every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr) begin
            r_mem[r_tgt] <= w_cnt_new;
        end
        r_rd_data <= r_mem[n_tgt];
        r_rd_vld  <= r_valid[n_tgt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_valid[r_tgt] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= NW'(RST_N);
            r_push_ptr  <= '0;
            r_steal_ptr <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.res_emit;
            if (i_cfg_we) begin
                r_n <= w_cfg_n;
            end
            if (i_cmd.tgt_load && w_outside) begin
                r_push_ptr <= f_next(w_push_q, r_n);
            end
            if (i_cmd.steal_found) begin
                r_steal_ptr <= f_next(r_tgt, r_n);
            end else if (i_cmd.steal_miss) begin
                r_steal_ptr <= f_next(r_start, r_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_req;
        end
        r_tgt <= n_tgt;
        if (i_cmd.scan_init) begin
            r_start <= w_steal_start;
            r_idx   <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + PW'(1);
        end
        if (i_cmd.res_emit) begin
            r_res.granted       <= i_cmd.res_grant;
            r_res.target_worker <= i_cmd.res_grant ? WID_W'(r_tgt) : '0;
            r_res.stolen        <= i_cmd.res_grant && i_cmd.res_steal
                                   && (32'(r_tgt) != 32'(r_req.worker_id));
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_wr && !w_is_push |-> w_cnt != '0)
        else $error("pop written to an empty count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_wr && w_is_push |-> w_cnt != '1)
        else $error("push written to a full count");

    a_stolen_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.stolen |-> r_res.granted && !w_is_push)
        else $error("steal flagged without a granted pop");

    a_refused_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !r_res.granted |-> r_res.target_worker == '0 && !r_res.stolen)
        else $error("refused result carries a target");

endmodule

// ===== sv/work_stealing_queue_selector.sv =====
// work_stealing_queue_selector: per-worker job counts with round-robin push and steal
// top level joining wsqs_ctrl and wsqs_dp; depends on wsqs_pkg
//
// a request (push or pop) is taken on a rising edge with start high and busy low,
// and busy stays high until its result has been formed
// each result is shown on o_res for one cycle with o_done high; no stall is possible
// a push or a local pop passes through the decode and check states before o_done
// a request naming an out-of-range worker (but a push from outside) is refused
// a steal reads the job count memory one queue per cycle from the steal pointer,
// visiting each active worker's queue at most once until one holds a job
// the next request may be accepted in the cycle its predecessor's result is shown
// the one configuration register (active worker count) is written through
// i_cfg_valid / o_cfg_ready and is ready only while no request is in progress
// synchronous reset clears all job counts, both pointers; active = min(16, MAX_WORKERS)
`timescale 1ns / 1ps

module work_stealing_queue_selector #(
    parameter int MAX_WORKERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  wsqs_pkg::t_req              i_req,
    output logic                        o_done,
    output wsqs_pkg::t_res              o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [wsqs_pkg::CFG_W-1:0]  i_cfg_data
);
    import wsqs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    wsqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    wsqs_dp #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && !w_busy),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res),
        .o_done     (o_done)
    );

    assign busy        = w_busy;
    assign o_cfg_ready = !w_busy;

endmodule
